// ----- src/bcap_pkg.sv -----
package bcap_pkg;

  // Defaults for the top-level parameters
  localparam int WINDOW_DEF      = 40;
  localparam int CAPTURE_MAX_DEF = 1024;

  // Field widths
  localparam int SAMPLE_W   = 12;
  localparam int DAC_W      = 16;
  localparam int DAC_SHIFT  = 4;
  localparam int WORD_W     = 27;
  localparam int WORD_SHIFT = 15;
  localparam int POS_W      = 10;
  localparam int LEN_W      = 11;

  // Stream widths (tdata padded to whole bytes)
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 56;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_START  = 1'b1
  } op_t;

  // Per-item record handed from the window stage to the output stage
  typedef struct packed {
    logic [DAC_W-1:0] dac;
    logic             word_valid;
    logic [POS_W-1:0] pos;
    logic             done;
    logic             running;
  } bcap_rec_t;

endpackage

// ----- src/bcap_front.sv -----
module bcap_front #(
  parameter  int WINDOW      = bcap_pkg::WINDOW_DEF,
  parameter  int CAPTURE_MAX = bcap_pkg::CAPTURE_MAX_DEF,
  localparam int SumW        = bcap_pkg::SAMPLE_W + $clog2(WINDOW)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  bcap_pkg::op_t                in_op,
  input  logic [bcap_pkg::SAMPLE_W-1:0] in_sample,
  input  logic [bcap_pkg::LEN_W-1:0]   cfg_len,
  output logic                         s1_valid,
  output bcap_pkg::bcap_rec_t          s1_rec,
  output logic [SumW-1:0]              s1_sum,
  input  logic                         s2_ready
);
  import bcap_pkg::*;

  localparam int CntW = $clog2(WINDOW);
  localparam logic [CntW-1:0]  WRAP_AT = CntW'(WINDOW - 1);
  localparam logic [LEN_W-1:0] LEN_CAP =
    LEN_W'((CAPTURE_MAX > ((1 << LEN_W) - 1)) ? ((1 << LEN_W) - 1) : CAPTURE_MAX);

  logic [CntW-1:0]  wcnt_r, wcnt_nxt;
  logic [SumW-1:0]  wsum_r, wsum_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             s1_valid_r, s1_valid_nxt;
  bcap_rec_t        rec_r, rec_nxt;
  logic [SumW-1:0]  sum_r, sum_nxt;

  logic             in_fire;
  logic [LEN_W-1:0] len_eff;
  logic [SumW-1:0]  sum_add;

  assign in_ready = !s1_valid_r || s2_ready;
  assign in_fire  = in_valid && in_ready;
  assign len_eff  = (cfg_len > LEN_CAP) ? LEN_CAP : cfg_len;
  assign sum_add  = wsum_r + SumW'(in_sample);

  always_comb begin
    wcnt_nxt = wcnt_r;
    wsum_nxt = wsum_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    rec_nxt  = '0;
    sum_nxt  = '0;
    case (in_op)
      OP_START: begin
        // odd length: start is ignored
        if (!len_eff[0]) begin
          cnt_nxt = '0;
          run_nxt = (len_eff != '0);
        end
      end
      OP_SAMPLE: begin
        rec_nxt.dac = {in_sample, {DAC_SHIFT{1'b0}}};
        if (wcnt_r == WRAP_AT) begin
          wcnt_nxt = '0;
          wsum_nxt = '0;
          if (run_r) begin
            rec_nxt.word_valid = 1'b1;
            rec_nxt.pos        = cnt_r[POS_W-1:0];
            sum_nxt            = sum_add;
            cnt_nxt            = cnt_r + 1'b1;
          end
        end else begin
          wcnt_nxt = wcnt_r + 1'b1;
          wsum_nxt = sum_add;
        end
        // also stops a capture whose length was lowered under it
        if (run_r && (cnt_nxt >= len_eff)) begin
          run_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
    rec_nxt.done    = (cnt_nxt == len_eff);
    rec_nxt.running = run_nxt;
  end

  always_comb begin
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s2_ready) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcnt_r     <= '0;
      wsum_r     <= '0;
      cnt_r      <= '0;
      run_r      <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (in_fire) begin
        wcnt_r <= wcnt_nxt;
        wsum_r <= wsum_nxt;
        cnt_r  <= cnt_nxt;
        run_r  <= run_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rec_r <= rec_nxt;
      sum_r <= sum_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_rec   = rec_r;
  assign s1_sum   = sum_r;

endmodule

// ----- src/boxcar_decimating_capture_top.sv -----
// Channel  Dir  Ports                        Item contents (lowest bit first)
// in_      in   in_tvalid/tready/tdata/tuser tdata: sample[11:0]; tuser: op
// out_     out  out_tvalid/tready/tdata/tuser tdata: dac_word, capture_word,
//                                            capture_position, capture_done,
//                                            capture_running; tuser: word_valid
// cfg_     in   cfg_valid/ready/data         data: capture_length[10:0]
//
// One item per cycle sustained while out_tready stays high; an accepted input is
// registered in the window/capture stage, then in the divide-by-WINDOW multiply stage.
// rst_n is synchronous, active low; it clears the window, the capture state,
// capture_length and both stage valids. cfg_ready is always high.
// A stalled out_tready holds the output register; the window stage keeps one
// item behind it before in_tready drops, and both ready paths recover in the
// cycle out_tready returns.
module boxcar_decimating_capture_top #(
  parameter int WINDOW      = bcap_pkg::WINDOW_DEF,
  parameter int CAPTURE_MAX = bcap_pkg::CAPTURE_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: sample[11:0], zero padding [15:12]
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bcap_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: op (0 = sample, 1 = start capture)
  input  logic                            in_tuser,
  // out_tdata: dac_word[15:0], capture_word[42:16], capture_position[52:43],
  //            capture_done[53], capture_running[54], zero [55]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bcap_pkg::OUT_DATA_W-1:0] out_tdata,
  // out_tuser: word_valid
  output logic                            out_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bcap_pkg::LEN_W-1:0]      cfg_data
);
  import bcap_pkg::*;

  // Exact floor divide by WINDOW: sum * ceil(2^S / WINDOW) >> S, valid for
  // every sum below 2^SumW when S = SumW + ceil(log2(WINDOW)).
  localparam int DivL = $clog2(WINDOW);
  localparam int SumW = SAMPLE_W + DivL;
  localparam int DivS = SumW + DivL;
  localparam int MulW = SumW + 1;
  localparam int ProdW = SumW + MulW;
  localparam logic [MulW-1:0] MUL_K =
    MulW'(((longint'(1) << DivS) + longint'(WINDOW) - 1) / longint'(WINDOW));

  logic [LEN_W-1:0]      cfg_len_r;
  logic                  s1_valid;
  bcap_rec_t             s1_rec;
  logic [SumW-1:0]       s1_sum;
  logic                  s2_ready;
  logic                  s2_load;
  logic [ProdW-1:0]      prod;
  logic [SAMPLE_W-1:0]   avg;
  logic [WORD_W-1:0]     word;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_user_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r <= '0;
    end else if (cfg_valid) begin
      cfg_len_r <= cfg_data;
    end
  end

  bcap_front #(
    .WINDOW      (WINDOW),
    .CAPTURE_MAX (CAPTURE_MAX)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (op_t'(in_tuser)),
    .in_sample (in_tdata[SAMPLE_W-1:0]),
    .cfg_len   (cfg_len_r),
    .s1_valid  (s1_valid),
    .s1_rec    (s1_rec),
    .s1_sum    (s1_sum),
    .s2_ready  (s2_ready)
  );

  // Output stage: one multiply, then the output register
  assign s2_ready = !out_valid_r || out_tready;
  assign s2_load  = s1_valid && s2_ready;

  // s1_sum is zero unless a word is emitted, so word is zero otherwise
  assign prod = ProdW'(s1_sum) * ProdW'(MUL_K);
  assign avg  = prod[DivS +: SAMPLE_W];
  assign word = {avg, {WORD_SHIFT{1'b0}}};

  always_comb begin
    if (s2_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      out_data_r <= {1'b0, s1_rec.running, s1_rec.done, s1_rec.pos, word, s1_rec.dac};
      out_user_r <= s1_rec.word_valid;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
